>>> rtl/core/indent_aware_markup_lexer_macros.svh
// Assertion macros shared by the lexer core files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef INDENT_AWARE_MARKUP_LEXER_MACROS_SVH
`define INDENT_AWARE_MARKUP_LEXER_MACROS_SVH

// same-cycle implication
`define IAML_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: check failed");

// next-cycle implication
`define IAML_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: check failed");

`endif

>>> rtl/core/iaml_pkg.sv
// Shared types and constants of the markup lexer core.
// No dependencies; imported by the channels, controller, datapath and top.
`timescale 1ns / 1ps

package iaml_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic       final_char;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start_offset;
      logic [15:0] end_offset;
      logic [15:0] line_no;
      logic [15:0] column_no;
      logic        run_last;
   } rsp_word_type;

   typedef struct packed {
      logic accept;
      logic scan_step;
      logic close_step;
      logic close_load;
      logic finish;
      logic flush_step;
      logic clear;
      logic release_last;
   } iaml_cmd_type;

   typedef struct packed {
      logic pass_again;
      logic pass_close;
      logic close_more;
      logic depth_nz;
      logic fin;
      logic can_emit;
   } iaml_status_type;

   localparam logic [3:0] KIND_EQ    = 4'd0;
   localparam logic [3:0] KIND_DYN   = 4'd1;
   localparam logic [3:0] KIND_STAT  = 4'd2;
   localparam logic [3:0] KIND_HASH  = 4'd3;
   localparam logic [3:0] KIND_DOT   = 4'd4;
   localparam logic [3:0] KIND_ID    = 4'd5;
   localparam logic [3:0] KIND_LIT   = 4'd6;
   localparam logic [3:0] KIND_OPEN  = 4'd7;
   localparam logic [3:0] KIND_CLOSE = 4'd8;
   localparam logic [3:0] KIND_NL    = 4'd9;
   localparam logic [3:0] KIND_TEXT  = 4'd10;
   localparam logic [3:0] KIND_BAD   = 4'd11;
   localparam logic [3:0] KIND_DEEP  = 4'd12;

   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;

   localparam logic [5:0] MAX_RESULTS = 6'd34;

endpackage

>>> rtl/core/iaml_channels_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on iaml_pkg for the word types.
`timescale 1ns / 1ps

interface iaml_req_if import iaml_pkg::*; ;
   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface iaml_rsp_if import iaml_pkg::*; ;
   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

>>> rtl/core/iaml_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iaml_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/core/iaml_ctrl.sv
// Sequencer of the lexer: accept, scan passes, block-close loop, flush, release.
// Depends on iaml_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "indent_aware_markup_lexer_macros.svh"

module iaml_ctrl import iaml_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  iaml_status_type st,
   output iaml_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_CLOSE = 3'd2;
   localparam logic [2:0] ST_CWAIT = 3'd3;
   localparam logic [2:0] ST_END   = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (st.can_emit) begin
               cmd.scan_step = 1'b1;
               if (st.pass_close) begin
                  state_in = ST_CLOSE;
               end else if (st.pass_again) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_END;
               end
            end
         end
         ST_CLOSE: begin
            if (!st.close_more) begin
               state_in = ST_SCAN;
            end else if (st.can_emit) begin
               cmd.close_step = 1'b1;
               state_in       = ST_CWAIT;
            end
         end
         ST_CWAIT: begin
            cmd.close_load = 1'b1;
            state_in       = ST_CLOSE;
         end
         ST_END: begin
            cmd.finish = 1'b1;
            state_in   = st.fin ? ST_FLUSH : ST_DONE;
         end
         ST_FLUSH: begin
            if (!st.depth_nz) begin
               cmd.clear = 1'b1;
               state_in  = ST_DONE;
            end else if (st.can_emit) begin
               cmd.flush_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (st.can_emit) begin
               cmd.release_last = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `IAML_ASSERT_NXT(a_accept_scans, clock, reset, cmd.accept, state_ff == ST_SCAN)
   `IAML_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))
   `IAML_ASSERT_NXT(a_release_ready, clock, reset, cmd.release_last, req_ready)

endmodule

>>> rtl/core/iaml_datapath.sv
// Lexer datapath: scan-state logic, positions, indent stack and result buffering.
// Depends on iaml_pkg, iaml_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "indent_aware_markup_lexer_macros.svh"

module iaml_datapath import iaml_pkg::*; #(
   parameter int MAX_LEVELS  = 32,
   parameter int OFFSET_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  iaml_cmd_type    cmd,
   output iaml_status_type st,
   input  req_word_type    req_word,
   output logic            rsp_valid,
   output rsp_word_type    rsp_word,
   input  logic            rsp_ready
);

   localparam int DW = $clog2(MAX_LEVELS);
   localparam int OB = OFFSET_BITS;

   localparam logic [3:0] SS_START = 4'd0;
   localparam logic [3:0] SS_ID    = 4'd1;
   localparam logic [3:0] SS_LIT   = 4'd2;
   localparam logic [3:0] SS_ESC   = 4'd3;
   localparam logic [3:0] SS_CPOS  = 4'd4;
   localparam logic [3:0] SS_COM   = 4'd5;
   localparam logic [3:0] SS_CNL   = 4'd6;
   localparam logic [3:0] SS_LINE  = 4'd7;
   localparam logic [3:0] SS_TEXT  = 4'd8;

   function automatic logic [OB-1:0] off_inc(input logic [OB-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [OB-1:0] off_dec(input logic [OB-1:0] v);
      return (v == '0) ? v : v - 1'b1;
   endfunction

   // lexer state
   logic [3:0]    scan_ff, scan_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [7:0]    top_ff, top_in;
   logic [OB-1:0] char_off_ff, char_off_in;
   logic [OB-1:0] lex_begin_ff, lex_begin_in;
   logic [OB-1:0] lex_finish_ff, lex_finish_in;
   logic [7:0]    com_indent_ff, com_indent_in;
   logic [15:0]   line_ff, line_in;
   logic [15:0]   col_ff, col_in;
   logic [3:0]    prev_kind_ff, prev_kind_in;
   logic          seen_ff, seen_in;

   // current word and loop bound
   logic [7:0]    ch_ff;
   logic          fin_ff;
   logic [7:0]    close_width_ff, close_width_in;

   // result buffering
   logic [5:0]    cnt_ff, cnt_in;
   logic          hold_valid_ff, hold_valid_in;
   rsp_word_type  hold_ff, hold_in;
   logic          out_valid_ff, out_valid_in;
   rsp_word_type  out_ff, out_in;

   // one scan pass
   logic [3:0]    p_scan;
   logic [OB-1:0] p_lb, p_lf;
   logic [7:0]    p_ci;
   logic          p_tok, p_err, p_again, p_close, p_push;
   logic [3:0]    p_kind;
   logic [OB-1:0] p_s, p_e;
   logic [7:0]    p_close_w, p_n;
   logic [OB-1:0] p_d;

   logic          emit_v, emit_store, out_free;
   rsp_word_type  emit_word;

   logic          ram_we;
   logic [DW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_rdata;

   always_comb begin
      p_scan    = scan_ff;
      p_lb      = lex_begin_ff;
      p_lf      = lex_finish_ff;
      p_ci      = com_indent_ff;
      p_tok     = 1'b0;
      p_err     = 1'b0;
      p_again   = 1'b0;
      p_close   = 1'b0;
      p_push    = 1'b0;
      p_kind    = KIND_EQ;
      p_s       = char_off_ff;
      p_e       = char_off_ff;
      p_close_w = com_indent_ff;
      p_d       = (char_off_ff > lex_begin_ff) ? char_off_ff - lex_begin_ff : '0;
      p_n       = (p_d > OB'(8'hFF)) ? 8'hFF : p_d[7:0];
      case (scan_ff)
         SS_START: begin
            p_lb = char_off_ff;
            p_lf = char_off_ff;
            if (ch_ff inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]}) begin
               p_scan = SS_ID;
            end else begin
               case (ch_ff)
                  CH_QUOTE: p_scan = SS_LIT;
                  CH_SLASH: p_scan = SS_CPOS;
                  CH_NEWLINE, CH_COLON: begin
                     p_scan = SS_LINE;
                     p_lb   = off_inc(char_off_ff);
                  end
                  CH_PIPE: begin
                     p_scan = SS_TEXT;
                     p_lb   = off_inc(char_off_ff);
                  end
                  CH_EQ: begin
                     p_tok  = 1'b1;
                     p_kind = KIND_EQ;
                  end
                  CH_MINUS: begin
                     p_tok  = 1'b1;
                     p_kind = KIND_DYN;
                  end
                  CH_PLUS: begin
                     p_tok  = 1'b1;
                     p_kind = KIND_STAT;
                  end
                  CH_HASH: begin
                     p_tok  = 1'b1;
                     p_kind = KIND_HASH;
                  end
                  CH_DOT: begin
                     p_tok  = 1'b1;
                     p_kind = KIND_DOT;
                  end
                  CH_SPACE: begin
                  end
                  default: begin
                     p_tok  = 1'b1;
                     p_err  = 1'b1;
                     p_kind = KIND_BAD;
                  end
               endcase
            end
         end
         SS_ID: begin
            if (!(ch_ff inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z],
                                [CH_DIGIT_0:CH_DIGIT_9], CH_MINUS})) begin
               p_lf    = off_dec(char_off_ff);
               p_scan  = SS_START;
               p_tok   = 1'b1;
               p_kind  = KIND_ID;
               p_s     = lex_begin_ff;
               p_e     = off_dec(char_off_ff);
               p_again = 1'b1;
            end
         end
         SS_LIT: begin
            if (ch_ff == CH_QUOTE) begin
               p_scan = SS_START;
               p_lf   = char_off_ff;
               p_tok  = 1'b1;
               p_kind = KIND_LIT;
               p_s    = lex_begin_ff;
            end else if (ch_ff == CH_BSLASH) begin
               p_scan = SS_ESC;
            end
         end
         SS_ESC: begin
            if (ch_ff == CH_QUOTE) begin
               p_scan = SS_LIT;
            end
         end
         SS_CPOS: begin
            if (ch_ff == CH_SLASH) begin
               p_scan = SS_COM;
            end
         end
         SS_COM: begin
            if (ch_ff == CH_NEWLINE) begin
               p_scan = SS_CNL;
               p_ci   = '0;
            end
         end
         SS_CNL: begin
            if (ch_ff == CH_SPACE) begin
               p_ci = (com_indent_ff == 8'hFF) ? com_indent_ff : com_indent_ff + 8'd1;
            end else if (top_ff < com_indent_ff) begin
               p_scan = SS_COM;
            end else begin
               p_scan  = SS_START;
               p_lf    = off_dec(char_off_ff);
               p_close = 1'b1;
               p_again = 1'b1;
            end
         end
         SS_LINE: begin
            if (ch_ff != CH_SPACE) begin
               p_lf    = char_off_ff;
               p_scan  = SS_START;
               p_again = 1'b1;
               if (p_n > top_ff) begin
                  p_tok = 1'b1;
                  if (depth_ff == DW'(MAX_LEVELS - 1)) begin
                     p_err  = 1'b1;
                     p_kind = KIND_DEEP;
                  end else begin
                     p_push = 1'b1;
                     p_kind = KIND_OPEN;
                     p_s    = lex_begin_ff;
                  end
               end else if (p_n < top_ff) begin
                  p_close   = 1'b1;
                  p_close_w = p_n;
               end else if (char_off_ff != '0) begin
                  if (!(seen_ff && prev_kind_ff == KIND_CLOSE)) begin
                     p_tok  = 1'b1;
                     p_kind = KIND_NL;
                     p_s    = lex_begin_ff;
                  end
               end
            end
         end
         SS_TEXT: begin
            if (ch_ff == CH_NEWLINE) begin
               p_tok  = 1'b1;
               p_kind = KIND_TEXT;
               p_s    = lex_begin_ff;
               p_e    = lex_finish_ff;
               p_scan = SS_LINE;
               p_lb   = off_inc(char_off_ff);
            end
         end
         default: begin
            p_scan = SS_START;
         end
      endcase
   end

   // result word for this cycle
   always_comb begin
      emit_word          = '0;
      emit_v             = 1'b0;
      if (cmd.scan_step && p_tok) begin
         emit_v                 = 1'b1;
         emit_word.kind         = p_kind;
         emit_word.start_offset = 16'(p_s);
         emit_word.end_offset   = 16'(p_e);
         emit_word.line_no      = p_err ? line_ff : 16'd0;
         emit_word.column_no    = p_err ? col_ff : 16'd0;
      end else if (cmd.close_step || cmd.flush_step) begin
         emit_v                 = 1'b1;
         emit_word.kind         = KIND_CLOSE;
         emit_word.start_offset = 16'(lex_begin_ff);
         emit_word.end_offset   = 16'(lex_finish_ff);
      end
   end

   assign out_free   = !out_valid_ff || rsp_ready;
   assign emit_store = emit_v && (cnt_ff < MAX_RESULTS);

   assign st.pass_again = p_again;
   assign st.pass_close = p_close;
   assign st.close_more = (depth_ff != '0) && (top_ff > close_width_ff);
   assign st.depth_nz   = (depth_ff != '0);
   assign st.fin        = fin_ff;
   assign st.can_emit   = !hold_valid_ff || out_free;

   assign ram_we    = cmd.scan_step && p_push;
   assign ram_waddr = depth_ff + 1'b1;
   assign ram_raddr = depth_ff - 1'b1;

   iaml_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LEVELS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (p_n),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      scan_in        = scan_ff;
      depth_in       = depth_ff;
      top_in         = top_ff;
      char_off_in    = char_off_ff;
      lex_begin_in   = lex_begin_ff;
      lex_finish_in  = lex_finish_ff;
      com_indent_in  = com_indent_ff;
      line_in        = line_ff;
      col_in         = col_ff;
      prev_kind_in   = prev_kind_ff;
      seen_in        = seen_ff;
      close_width_in = close_width_ff;
      cnt_in         = cnt_ff;
      hold_valid_in  = hold_valid_ff;
      hold_in        = hold_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_in         = out_ff;

      if (cmd.accept) begin
         cnt_in = '0;
         if (req_word.ch == CH_NEWLINE) begin
            line_in = (line_ff == 16'hFFFF) ? line_ff : line_ff + 16'd1;
            col_in  = '0;
         end else begin
            col_in  = (col_ff == 16'hFFFF) ? col_ff : col_ff + 16'd1;
         end
      end

      if (cmd.scan_step) begin
         scan_in       = p_scan;
         lex_begin_in  = p_lb;
         lex_finish_in = p_lf;
         com_indent_in = p_ci;
         if (p_close) begin
            close_width_in = p_close_w;
         end
         if (p_push) begin
            depth_in = depth_ff + 1'b1;
            top_in   = p_n;
         end
      end

      if (cmd.close_step || cmd.flush_step) begin
         depth_in = depth_ff - 1'b1;
      end

      if (cmd.close_load) begin
         top_in = (depth_ff == '0) ? 8'd0 : ram_rdata;
      end

      if (cmd.finish) begin
         char_off_in = off_inc(char_off_ff);
      end

      if (emit_v && (emit_word.kind <= KIND_TEXT)) begin
         prev_kind_in = emit_word.kind;
         seen_in      = 1'b1;
      end

      if (emit_store) begin
         cnt_in        = cnt_ff + 6'd1;
         hold_in       = emit_word;
         hold_valid_in = 1'b1;
         if (hold_valid_ff) begin
            out_in       = hold_ff;
            out_valid_in = 1'b1;
         end
      end

      if (cmd.release_last && hold_valid_ff) begin
         out_in          = hold_ff;
         out_in.run_last = 1'b1;
         out_valid_in    = 1'b1;
         hold_valid_in   = 1'b0;
      end

      if (cmd.clear) begin
         scan_in       = SS_LINE;
         depth_in      = '0;
         top_in        = '0;
         char_off_in   = '0;
         lex_begin_in  = '0;
         lex_finish_in = '0;
         com_indent_in = '0;
         line_in       = '0;
         col_in        = '0;
         prev_kind_in  = '0;
         seen_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= SS_LINE;
         depth_ff      <= '0;
         top_ff        <= '0;
         char_off_ff   <= '0;
         lex_begin_ff  <= '0;
         lex_finish_ff <= '0;
         com_indent_ff <= '0;
         line_ff       <= '0;
         col_ff        <= '0;
         prev_kind_ff  <= '0;
         seen_ff       <= 1'b0;
         cnt_ff        <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         scan_ff       <= scan_in;
         depth_ff      <= depth_in;
         top_ff        <= top_in;
         char_off_ff   <= char_off_in;
         lex_begin_ff  <= lex_begin_in;
         lex_finish_ff <= lex_finish_in;
         com_indent_ff <= com_indent_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         prev_kind_ff  <= prev_kind_in;
         seen_ff       <= seen_in;
         cnt_ff        <= cnt_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff  <= req_word.ch;
         fin_ff <= req_word.final_char;
      end
      close_width_ff <= close_width_in;
      hold_ff        <= hold_in;
      out_ff         <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   `IAML_ASSERT_NXT(a_release_empties, clock, reset, cmd.release_last, !hold_valid_ff)
   `IAML_ASSERT_NXT(a_clear_resets, clock, reset, cmd.clear,
                    (depth_ff == '0) && (scan_ff == SS_LINE) && (char_off_ff == '0))
   `IAML_ASSERT_IMP(a_no_overwrite, clock, reset, emit_store && hold_valid_ff,
                    !out_valid_ff || rsp_ready)

endmodule

>>> rtl/core/indent_aware_markup_lexer.sv
// Sequence: a one-pass character goes through accept, scan, end and release; a pushback
// adds another scan pass, each block close inside a line adds a close and a wait state
// (indent stack RAM read), leaving the close loop passes through the close state again,
// and the final flush adds a flush step per close plus a clearing step.
// Throughput: a new word is accepted only in idle, after the last one is released.
// Reset: synchronous, active high; line-level state, empty stack, no clearing pass.
`timescale 1ns / 1ps

module indent_aware_markup_lexer import iaml_pkg::*; #(
   parameter int MAX_LEVELS  = 32,
   parameter int OFFSET_BITS = 16
) (
   input logic           clock,
   input logic           reset,
   iaml_req_if.sink      req_chan,
   iaml_rsp_if.source    rsp_chan
);

   iaml_cmd_type    cmd;
   iaml_status_type st;
   logic            req_ready;
   logic            rsp_valid;
   rsp_word_type    rsp_word;

   iaml_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   iaml_datapath #(
      .MAX_LEVELS  (MAX_LEVELS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_word  (req_chan.word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_ready (rsp_chan.ready)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.word  = rsp_word;

endmodule
